// ===== rtl/mer_pkg.sv =====
package mer_pkg;

	localparam int STAMP_W = 32;
	localparam int COUNT_W = 16;
	localparam int RATE_W  = 28;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;
	// ms per minute times Q8 scale
	localparam int RATE_SCALE = 60000 * 256;

	localparam logic [15:0]        DEBOUNCE_RST  = 16'd500;
	localparam logic [STAMP_W-1:0] HEARTBEAT_RST = 32'd5000;

	localparam logic REG_DEBOUNCE  = 1'b0;
	localparam logic REG_HEARTBEAT = 1'b1;

	localparam logic CAUSE_TRIGGER   = 1'b0;
	localparam logic CAUSE_HEARTBEAT = 1'b1;

	typedef struct packed {
		logic [STAMP_W-1:0] time_ms;
		logic               motion_level;
	} sample_t;

	typedef struct packed {
		logic [COUNT_W-1:0] total_triggers;
		logic [COUNT_W-1:0] recent_triggers;
		logic [RATE_W-1:0]  rate_q8;
		logic [STAMP_W-1:0] last_trigger_time;
		logic               active_now;
		logic               report_cause;
		logic               last_of_run;
	} report_t;

	// stamp/valid shift toward the tail; lo/hi carry the running window min/max
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic               valid;
		logic [STAMP_W-1:0] lo;
		logic [STAMP_W-1:0] hi;
	} mer_link_t;

endpackage

// ===== rtl/mer_cell.sv =====
module mer_cell
	import mer_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  mer_link_t link_in,
	output mer_link_t link_out
);

	logic               valid_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [STAMP_W-1:0] lo_q;
	logic [STAMP_W-1:0] hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			stamp_q <= link_in.stamp;
		end
		lo_q <= (valid_q && stamp_q < link_in.lo) ? stamp_q : link_in.lo;
		hi_q <= (valid_q && stamp_q > link_in.hi) ? stamp_q : link_in.hi;
	end

	assign link_out.stamp = stamp_q;
	assign link_out.valid = valid_q;
	assign link_out.lo    = lo_q;
	assign link_out.hi    = hi_q;

endmodule

// ===== rtl/mer_divider.sv =====
module mer_divider #(
	parameter int NUM_W = 28
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [31:0]      den,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic [NUM_W-1:0] quo_q;
	logic [32:0]      rem_sh;
	logic [32:0]      diff;
	logic             fits;

	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/motion_event_rate_monitor.sv =====
// Flow: after acceptance, a sample that triggers or is due a heartbeat runs the min/max pass
// along the cell chain (S_SWEEP), then the bit-serial divider (S_DIV), then emits its reports;
// the divider is skipped when the rate is zero. A sample with no report leaves the monitor idle.
// One sample at a time: sample_ready is low from the sweep until the last report is loaded,
// so the sweep, the divider, one or two reports and any output stall hold off the next sample.
// Reset: arst_n clears counters, stamps, ring fill and registers to their defaults.
module motion_event_rate_monitor
	import mer_pkg::*;
#(
	parameter int RING_DEPTH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        report_valid,
	input  logic        report_ready,
	output report_t     report,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int NUM_MAX = (RING_DEPTH - 1) * RATE_SCALE;
	localparam int NUM_W   = $clog2(NUM_MAX + 1);
	localparam int FILL_W  = $clog2(RING_DEPTH + 1);
	localparam int CNT_W   = $clog2(RING_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SWEEP = 6'b000010,
		S_PREP  = 6'b000100,
		S_DIV   = 6'b001000,
		S_EMIT1 = 6'b010000,
		S_EMIT2 = 6'b100000
	} state_t;

	state_t state_q;

	logic [15:0]        debounce_q;
	logic [STAMP_W-1:0] heartbeat_q;
	logic               prev_level_q;
	logic [STAMP_W-1:0] last_trig_q;
	logic [STAMP_W-1:0] last_hb_q;
	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] recent_q;
	logic [COUNT_W-1:0] rep_recent_q;
	logic [FILL_W-1:0]  fill_q;
	logic [CNT_W-1:0]   sweep_cnt_q;
	logic               trig_q;
	logic               hb_q;
	logic [RATE_W-1:0]  rate_q;
	logic               out_valid_q;
	report_t            out_q;

	logic               accept;
	logic               trig;
	logic               hb;
	logic [STAMP_W-1:0] trig_gap;
	logic [STAMP_W-1:0] hb_gap;
	logic [COUNT_W-1:0] recent_next;
	logic               out_free;
	logic               out_load;
	logic               cfg_wr;

	mer_link_t          link [RING_DEPTH+1];
	logic [STAMP_W-1:0] span;
	logic [FILL_W-1:0]  fill_m1;
	logic [NUM_W-1:0]   num;
	logic               no_rate;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [RATE_W-1:0]  div_rate;
	report_t            rep_trig;
	report_t            rep_hb;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEARTBEAT) ? heartbeat_q : {16'b0, debounce_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= DEBOUNCE_RST;
			heartbeat_q <= HEARTBEAT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DEBOUNCE:  debounce_q  <= pwdata[15:0];
				REG_HEARTBEAT: heartbeat_q <= pwdata;
				default:       debounce_q  <= debounce_q;
			endcase
		end
	end

	// sample decode
	assign sample_ready = (state_q == S_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign trig_gap     = sample.time_ms - last_trig_q;
	assign hb_gap       = sample.time_ms - last_hb_q;
	assign trig         = sample.motion_level && !prev_level_q &&
	                      (trig_gap > {16'b0, debounce_q});
	assign hb           = hb_gap >= heartbeat_q;
	assign recent_next  = trig ? recent_q + 1'b1 : recent_q;

	// stamp chain
	assign link[0].stamp = sample.time_ms;
	assign link[0].valid = 1'b1;
	assign link[0].lo    = '1;
	assign link[0].hi    = '0;

	for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
		mer_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept && trig),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	// rate
	assign span      = link[RING_DEPTH].hi - link[RING_DEPTH].lo;
	assign fill_m1   = fill_q - 1'b1;
	assign num       = NUM_W'(32'(fill_m1) * 32'(RATE_SCALE));
	assign no_rate   = (fill_q < FILL_W'(2)) || (span == '0);
	assign div_start = (state_q == S_PREP) && !no_rate;
	assign div_rate  = (32'(div_quo) > 32'(RATE_MAX)) ? RATE_MAX : RATE_W'(div_quo);

	mer_divider #(
		.NUM_W (NUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (num),
		.den      (span),
		.done     (div_done),
		.quotient (div_quo)
	);

	// reports
	always_comb begin
		rep_trig.total_triggers    = total_q;
		rep_trig.recent_triggers   = rep_recent_q;
		rep_trig.rate_q8           = rate_q;
		rep_trig.last_trigger_time = last_trig_q;
		rep_trig.active_now        = prev_level_q;
		rep_trig.report_cause      = CAUSE_TRIGGER;
		rep_trig.last_of_run       = !hb_q;

		rep_hb                 = rep_trig;
		rep_hb.recent_triggers = trig_q ? '0 : rep_recent_q;
		rep_hb.report_cause    = CAUSE_HEARTBEAT;
		rep_hb.last_of_run     = 1'b1;
	end

	assign out_free = !out_valid_q || report_ready;
	assign out_load = ((state_q == S_EMIT1) || (state_q == S_EMIT2)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (report_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_level_q <= 1'b0;
			last_trig_q  <= '0;
			last_hb_q    <= '0;
			total_q      <= '0;
			recent_q     <= '0;
			fill_q       <= '0;
			sweep_cnt_q  <= '0;
			trig_q       <= 1'b0;
			hb_q         <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_level_q <= sample.motion_level;
						trig_q       <= trig;
						hb_q         <= hb;
						recent_q     <= (trig || hb) ? '0 : recent_next;
						sweep_cnt_q  <= '0;
						if (trig) begin
							total_q     <= total_q + 1'b1;
							last_trig_q <= sample.time_ms;
							if (fill_q != FILL_W'(RING_DEPTH)) begin
								fill_q <= fill_q + 1'b1;
							end
						end
						if (hb) begin
							last_hb_q <= sample.time_ms;
						end
						if (trig || hb) begin
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
					if (sweep_cnt_q == CNT_W'(RING_DEPTH - 1)) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (no_rate) begin
						state_q <= trig_q ? S_EMIT1 : S_EMIT2;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= trig_q ? S_EMIT1 : S_EMIT2;
					end
				end
				S_EMIT1: begin
					if (out_free) begin
						state_q <= hb_q ? S_EMIT2 : S_IDLE;
					end
				end
				S_EMIT2: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rep_recent_q <= recent_next;
		end
		if (state_q == S_PREP && no_rate) begin
			rate_q <= '0;
		end else if (state_q == S_DIV && div_done) begin
			rate_q <= div_rate;
		end
		if (state_q == S_EMIT1 && out_free) begin
			out_q <= rep_trig;
		end else if (state_q == S_EMIT2 && out_free) begin
			out_q <= rep_hb;
		end
	end

	assign report_valid = out_valid_q;
	assign report       = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_DEPTH))
		else $error("ring fill beyond depth");

	a_hb_last: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report.report_cause == CAUSE_HEARTBEAT |-> report.last_of_run)
		else $error("heartbeat report not last of run");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside divide state");

	a_idle_no_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !trig && !hb |=> state_q == S_IDLE)
		else $error("sample without report left idle");

endmodule
